>>> rtl/core/wbm_pkg.sv
// Shared types and constants of the wall box merge table.
// Used by wbm_ctrl, wbm_dp and wall_box_merge_table; depends on nothing.
`default_nettype none

package wbm_pkg;

  // Table size default and field widths.
  localparam int unsigned TABLE_DEPTH_DEF = 16;
  localparam int unsigned COORD_W   = 16;
  localparam int unsigned BOX_W     = 96;
  localparam int unsigned WIDTH_W   = 17;
  localparam int unsigned HEIGHT_W  = 16;
  localparam int unsigned KEY_W     = 39;
  localparam int unsigned AXKEY_W   = 13;
  localparam int unsigned MUL_W     = 18;
  localparam int unsigned PROD_W    = 36;
  localparam int unsigned SQ_W      = 34;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned SLOT_W    = 4;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned OUT_DATA_W = 104;

  // Reset values of the configuration registers.
  localparam logic [CFG_W-1:0] MIN_SIZE_RST  = 16'd500;
  localparam logic             MERGE_EN_RST  = 1'b1;

  // Rounding of a doubled center to 10 mm: (|c| + 10) / 20 via reciprocal.
  localparam logic [MUL_W-1:0] KEY_RECIP = 18'd52429;
  localparam logic [17:0]      KEY_BIAS  = 18'd10;
  localparam int unsigned      KEY_SHIFT = 20;

  // Same-plane limit on doubled y centers.
  localparam logic [16:0] PLANE_LIMIT = 17'd400;

  // Square root starts at the highest even bit of the radicand.
  localparam logic [SQ_W-1:0] SQRT_BIT0 = 34'h1_0000_0000;

  typedef enum logic [0:0] {
    CMD_OFFER = 1'b0,
    CMD_FLUSH = 1'b1
  } command_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_SIZE  = 1'b0,
    CFG_MERGE_EN  = 1'b1
  } cfg_idx_e;

  typedef enum logic [STATUS_W-1:0] {
    RES_TOO_SMALL   = 3'd0,
    RES_DUPLICATE   = 3'd1,
    RES_MERGED      = 3'd2,
    RES_INSERTED    = 3'd3,
    RES_TABLE_FULL  = 3'd4,
    RES_FLUSHED     = 3'd5,
    RES_FLUSH_EMPTY = 3'd6
  } res_status_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_SQ_DX,
    OP_SQ_DY,
    OP_SQ_M,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_KEY_X,
    OP_KEY_Y,
    OP_KEY_Z,
    OP_DC_X,
    OP_DC_Y,
    OP_DC_Z,
    OP_SUM_S,
    OP_MERGE_WR,
    OP_INS_WR
  } dp_op_e;

  typedef enum logic [1:0] {
    SLOT_ZERO,
    SLOT_IDX,
    SLOT_COUNT
  } slot_sel_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SQ_DX,
    S_SQ_DY,
    S_SQ_M,
    S_SIZE,
    S_KEY_X,
    S_KEY_Y,
    S_KEY_Z,
    S_SQRT,
    S_DUP_RD,
    S_DUP_CMP,
    S_MG_RD,
    S_MG_X,
    S_MG_Y,
    S_MG_Z,
    S_MG_S,
    S_MG_CMP,
    S_INS,
    S_FL_CHK,
    S_FL_RD,
    S_FL_EMIT
  } fsm_state_e;

  // Box corners, lowest field in the lowest bits.
  typedef struct packed {
    logic signed [COORD_W-1:0] hi_z;
    logic signed [COORD_W-1:0] hi_y;
    logic signed [COORD_W-1:0] hi_x;
    logic signed [COORD_W-1:0] lo_z;
    logic signed [COORD_W-1:0] lo_y;
    logic signed [COORD_W-1:0] lo_x;
  } box_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    dp_op_e      op;
    logic        load_in;
    logic        idx_clr;
    logic        idx_inc;
    logic        cnt_clr;
    logic        out_load;
    res_status_e out_status;
    slot_sel_e   slot_sel;
    logic        out_box;
    logic        out_last;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic too_small;
    logic sqrt_done;
    logic key_match;
    logic scan_end;
    logic last_entry;
    logic merge_hit;
    logic table_full;
    logic cnt_zero;
    logic out_free;
    logic merge_en;
  } dp_status_t;

endpackage

`default_nettype wire

>>> rtl/core/wbm_ctrl.sv
// Controller state machine of the wall box merge table.
// Depends on wbm_pkg; drives wbm_dp through dp_cmd_t and reads dp_status_t.
`default_nettype none

module wbm_ctrl
  import wbm_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic       in_command_i,
  output logic            in_ready_o,
  input  wire dp_status_t status_i,
  output dp_cmd_t         cmd_o
);

  fsm_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = (command_e'(in_command_i) == CMD_FLUSH) ? S_FL_CHK : S_SQ_DX;
        end
      end
      S_SQ_DX: state_d = S_SQ_DY;
      S_SQ_DY: state_d = S_SQ_M;
      S_SQ_M:  state_d = S_SIZE;
      S_SIZE: begin
        if (!status_i.too_small) begin
          state_d = S_KEY_X;
        end else if (status_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      S_KEY_X: state_d = S_KEY_Y;
      S_KEY_Y: state_d = S_KEY_Z;
      S_KEY_Z: state_d = S_SQRT;
      S_SQRT: begin
        if (status_i.sqrt_done) begin
          state_d = S_DUP_RD;
        end
      end
      S_DUP_RD: begin
        if (!status_i.scan_end) begin
          state_d = S_DUP_CMP;
        end else begin
          state_d = status_i.merge_en ? S_MG_RD : S_INS;
        end
      end
      S_DUP_CMP: begin
        if (!status_i.key_match) begin
          state_d = S_DUP_RD;
        end else if (status_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      S_MG_RD: state_d = status_i.scan_end ? S_INS : S_MG_X;
      S_MG_X:  state_d = S_MG_Y;
      S_MG_Y:  state_d = S_MG_Z;
      S_MG_Z:  state_d = S_MG_S;
      S_MG_S:  state_d = S_MG_CMP;
      S_MG_CMP: begin
        if (!status_i.merge_hit) begin
          state_d = S_MG_RD;
        end else if (status_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      S_INS: begin
        if (status_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      S_FL_CHK: begin
        if (!status_i.cnt_zero) begin
          state_d = S_FL_RD;
        end else if (status_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      S_FL_RD: state_d = S_FL_EMIT;
      S_FL_EMIT: begin
        if (status_i.out_free) begin
          state_d = status_i.last_entry ? S_IDLE : S_FL_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs: datapath commands and input ready.
  always_comb begin
    cmd_o            = '0;
    cmd_o.op         = OP_NONE;
    cmd_o.out_status = RES_TOO_SMALL;
    cmd_o.slot_sel   = SLOT_ZERO;
    in_ready_o       = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      S_SQ_DX: cmd_o.op = OP_SQ_DX;
      S_SQ_DY: cmd_o.op = OP_SQ_DY;
      S_SQ_M:  cmd_o.op = OP_SQ_M;
      S_SIZE: begin
        if (!status_i.too_small) begin
          cmd_o.op = OP_SQRT_INIT;
        end else if (status_i.out_free) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_status = RES_TOO_SMALL;
          cmd_o.out_last   = 1'b1;
        end
      end
      S_KEY_X: cmd_o.op = OP_KEY_X;
      S_KEY_Y: cmd_o.op = OP_KEY_Y;
      S_KEY_Z: cmd_o.op = OP_KEY_Z;
      S_SQRT: begin
        if (status_i.sqrt_done) begin
          cmd_o.idx_clr = 1'b1;
        end else begin
          cmd_o.op = OP_SQRT_STEP;
        end
      end
      S_DUP_RD: begin
        cmd_o.idx_clr = status_i.scan_end && status_i.merge_en;
      end
      S_DUP_CMP: begin
        if (!status_i.key_match) begin
          cmd_o.idx_inc = 1'b1;
        end else if (status_i.out_free) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_status = RES_DUPLICATE;
          cmd_o.slot_sel   = SLOT_IDX;
          cmd_o.out_last   = 1'b1;
        end
      end
      S_MG_X: cmd_o.op = OP_DC_X;
      S_MG_Y: cmd_o.op = OP_DC_Y;
      S_MG_Z: cmd_o.op = OP_DC_Z;
      S_MG_S: cmd_o.op = OP_SUM_S;
      S_MG_CMP: begin
        if (!status_i.merge_hit) begin
          cmd_o.idx_inc = 1'b1;
        end else if (status_i.out_free) begin
          cmd_o.op         = OP_MERGE_WR;
          cmd_o.out_load   = 1'b1;
          cmd_o.out_status = RES_MERGED;
          cmd_o.slot_sel   = SLOT_IDX;
          cmd_o.out_last   = 1'b1;
        end
      end
      S_INS: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_last = 1'b1;
          if (status_i.table_full) begin
            cmd_o.out_status = RES_TABLE_FULL;
          end else begin
            cmd_o.op         = OP_INS_WR;
            cmd_o.out_status = RES_INSERTED;
            cmd_o.slot_sel   = SLOT_COUNT;
          end
        end
      end
      S_FL_CHK: begin
        if (!status_i.cnt_zero) begin
          cmd_o.idx_clr = 1'b1;
        end else if (status_i.out_free) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_status = RES_FLUSH_EMPTY;
          cmd_o.out_last   = 1'b1;
        end
      end
      S_FL_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_status = RES_FLUSHED;
          cmd_o.slot_sel   = SLOT_IDX;
          cmd_o.out_box    = 1'b1;
          cmd_o.out_last   = status_i.last_entry;
          cmd_o.idx_inc    = 1'b1;
          cmd_o.cnt_clr    = status_i.last_entry;
        end
      end
      default: begin
        cmd_o.op = OP_NONE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/core/wbm_dp.sv
// Datapath of the wall box merge table: entry memories, shared multiplier,
// square root unit, configuration and output register. Depends on wbm_pkg.
`default_nettype none

module wbm_dp
  import wbm_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [CFG_W-1:0]       cfg_data_i,
  input  wire logic [BOX_W-1:0]       in_box_i,
  input  wire dp_cmd_t                cmd_i,
  output dp_status_t                  status_o,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic [STATUS_W-1:0]         out_status_o,
  output logic [SLOT_W-1:0]           out_slot_o,
  output logic [BOX_W-1:0]            out_box_o,
  output logic                        out_last_o
);

  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // Doubled center of one axis.
  function automatic logic signed [16:0] csum(input logic signed [15:0] a,
                                              input logic signed [15:0] b);
    return {a[15], a} + {b[15], b};
  endfunction

  // Union bounds of one axis, each box taken with its bounds in order.
  function automatic logic [31:0] union_axis(input logic signed [15:0] alo,
                                             input logic signed [15:0] ahi,
                                             input logic signed [15:0] blo,
                                             input logic signed [15:0] bhi);
    logic signed [15:0] amin, amax, bmin, bmax, umin, umax;
    amin = (alo < ahi) ? alo : ahi;
    amax = (alo < ahi) ? ahi : alo;
    bmin = (blo < bhi) ? blo : bhi;
    bmax = (blo < bhi) ? bhi : blo;
    umin = (amin < bmin) ? amin : bmin;
    umax = (amax > bmax) ? amax : bmax;
    return {umax, umin};
  endfunction

  // Configuration registers.
  logic [CFG_W-1:0] min_size_q;
  logic             merge_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_size_q <= MIN_SIZE_RST;
      merge_en_q <= MERGE_EN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MIN_SIZE: min_size_q <= cfg_data_i;
        CFG_MERGE_EN: merge_en_q <= cfg_data_i[0];
        default:      min_size_q <= min_size_q;
      endcase
    end
  end

  // Latched offered box.
  box_t in_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      in_q <= box_t'(in_box_i);
    end
  end

  // Side lengths and doubled centers of the offered box.
  logic signed [16:0] dx, dy, dz, dxn, dyn, dzn;
  logic [15:0]        adx_in, ady_in, h_in;
  logic signed [16:0] cx_in, cy_in, cz_in;

  assign dx     = {in_q.hi_x[15], in_q.hi_x} - {in_q.lo_x[15], in_q.lo_x};
  assign dy     = {in_q.hi_y[15], in_q.hi_y} - {in_q.lo_y[15], in_q.lo_y};
  assign dz     = {in_q.hi_z[15], in_q.hi_z} - {in_q.lo_z[15], in_q.lo_z};
  assign dxn    = -dx;
  assign dyn    = -dy;
  assign dzn    = -dz;
  assign adx_in = dx[16] ? dxn[15:0] : dx[15:0];
  assign ady_in = dy[16] ? dyn[15:0] : dy[15:0];
  assign h_in   = dz[16] ? dzn[15:0] : dz[15:0];
  assign cx_in  = csum(in_q.lo_x, in_q.hi_x);
  assign cy_in  = csum(in_q.lo_y, in_q.hi_y);
  assign cz_in  = csum(in_q.lo_z, in_q.hi_z);

  // Entry memories with registered read at the scan index.
  box_t              box_mem [TABLE_DEPTH];
  logic [WIDTH_W-1:0]  wid_mem [TABLE_DEPTH];
  logic [HEIGHT_W-1:0] hgt_mem [TABLE_DEPTH];
  logic [KEY_W-1:0]    key_mem [TABLE_DEPTH];

  box_t                rd_box_q;
  logic [WIDTH_W-1:0]  rd_w_q;
  logic [HEIGHT_W-1:0] rd_h_q;
  logic [KEY_W-1:0]    rd_key_q;

  logic [CNT_W-1:0] idx_q, cnt_q;

  // Scan index and entry count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      cnt_q <= '0;
    end else begin
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.cnt_clr) begin
        cnt_q <= '0;
      end else if (cmd_i.op == OP_INS_WR) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // Shared multiplier.
  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] prod;

  // Stored entry centers and their distances to the offered box.
  logic signed [16:0] cx_e, cy_e, cz_e;
  logic signed [17:0] dcx, dcy, dcz, dcxn, dcyn, dczn;
  logic [16:0]        adcx, adcy, adcz;

  assign cx_e = csum(rd_box_q.lo_x, rd_box_q.hi_x);
  assign cy_e = csum(rd_box_q.lo_y, rd_box_q.hi_y);
  assign cz_e = csum(rd_box_q.lo_z, rd_box_q.hi_z);
  assign dcx  = {cx_in[16], cx_in} - {cx_e[16], cx_e};
  assign dcy  = {cy_in[16], cy_in} - {cy_e[16], cy_e};
  assign dcz  = {cz_in[16], cz_in} - {cz_e[16], cz_e};
  assign dcxn = -dcx;
  assign dcyn = -dcy;
  assign dczn = -dcz;
  assign adcx = dcx[17] ? dcxn[16:0] : dcx[16:0];
  assign adcy = dcy[17] ? dcyn[16:0] : dcy[16:0];
  assign adcz = dcz[17] ? dczn[16:0] : dcz[16:0];

  // Larger size of each box, summed.
  logic [WIDTH_W-1:0] w_in;
  logic [WIDTH_W-1:0] big_in, big_e;
  logic [MUL_W-1:0]   s_sum;

  logic [SQ_W-1:0] sq_v_q, sq_r_q, sq_bit_q;

  assign w_in   = sq_r_q[WIDTH_W-1:0];
  assign big_in = (w_in > {1'b0, h_in}) ? w_in : {1'b0, h_in};
  assign big_e  = (rd_w_q > {1'b0, rd_h_q}) ? rd_w_q : {1'b0, rd_h_q};
  assign s_sum  = {1'b0, big_in} + {1'b0, big_e};

  // Key rounding operand for the selected axis.
  logic signed [16:0] key_c;
  logic signed [16:0] key_cn;
  logic [17:0]        key_a;

  always_comb begin
    case (cmd_i.op)
      OP_KEY_Y: key_c = cy_in;
      OP_KEY_Z: key_c = cz_in;
      default:  key_c = cx_in;
    endcase
  end

  assign key_cn = -key_c;
  assign key_a  = {1'b0, (key_c[16] ? key_cn : key_c)} + KEY_BIAS;

  // Multiplier operand selection.
  always_comb begin
    case (cmd_i.op)
      OP_SQ_DX: begin
        mul_a = {2'b00, adx_in};
        mul_b = {2'b00, adx_in};
      end
      OP_SQ_DY: begin
        mul_a = {2'b00, ady_in};
        mul_b = {2'b00, ady_in};
      end
      OP_SQ_M: begin
        mul_a = {2'b00, min_size_q};
        mul_b = {2'b00, min_size_q};
      end
      OP_KEY_X, OP_KEY_Y, OP_KEY_Z: begin
        mul_a = key_a;
        mul_b = KEY_RECIP;
      end
      OP_DC_X: begin
        mul_a = {1'b0, adcx};
        mul_b = {1'b0, adcx};
      end
      OP_DC_Y: begin
        mul_a = {1'b0, adcy};
        mul_b = {1'b0, adcy};
      end
      OP_DC_Z: begin
        mul_a = {1'b0, adcz};
        mul_b = {1'b0, adcz};
      end
      OP_SUM_S: begin
        mul_a = s_sum;
        mul_b = s_sum;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // Rounded axis key from the reciprocal product.
  logic [11:0]         key_q12;
  logic [AXKEY_W-1:0]  key_pos, key_k;

  assign key_q12 = prod[KEY_SHIFT+11:KEY_SHIFT];
  assign key_pos = {1'b0, key_q12};
  assign key_k   = key_c[16] ? (~key_pos + 1'b1) : key_pos;

  // Arithmetic registers.
  logic [SQ_W-1:0]   dxy_q;
  logic [31:0]       mm_q;
  logic [KEY_W-1:0]  key_q;
  logic [PROD_W-1:0] d_q, ss_q;
  logic [16:0]       adx_q, ady_q, adz_q;

  // One step of the bit-pair square root.
  logic [SQ_W-1:0] sq_trial;
  assign sq_trial = sq_r_q + sq_bit_q;

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_SQ_DX: dxy_q <= {2'b00, prod[31:0]};
      OP_SQ_DY: dxy_q <= dxy_q + {2'b00, prod[31:0]};
      OP_SQ_M:  mm_q  <= prod[31:0];
      OP_SQRT_INIT: begin
        sq_v_q   <= dxy_q;
        sq_r_q   <= '0;
        sq_bit_q <= SQRT_BIT0;
      end
      OP_SQRT_STEP: begin
        if (sq_v_q >= sq_trial) begin
          sq_v_q <= sq_v_q - sq_trial;
          sq_r_q <= (sq_r_q >> 1) + sq_bit_q;
        end else begin
          sq_r_q <= sq_r_q >> 1;
        end
        sq_bit_q <= sq_bit_q >> 2;
      end
      OP_KEY_X: key_q[AXKEY_W-1:0]           <= key_k;
      OP_KEY_Y: key_q[2*AXKEY_W-1:AXKEY_W]   <= key_k;
      OP_KEY_Z: key_q[3*AXKEY_W-1:2*AXKEY_W] <= key_k;
      OP_DC_X: begin
        d_q   <= prod;
        adx_q <= adcx;
      end
      OP_DC_Y: begin
        d_q   <= d_q + prod;
        ady_q <= adcy;
      end
      OP_DC_Z: begin
        d_q   <= d_q + prod;
        adz_q <= adcz;
      end
      OP_SUM_S: ss_q <= prod;
      default:  d_q  <= d_q;
    endcase
  end

  // Merge tests on the registered sums.
  logic [42:0] d100;
  logic [39:0] ss9;
  logic        near, plane, x_olap, z_olap;

  assign d100   = {1'b0, d_q, 6'b0} + {2'b0, d_q, 5'b0} + {5'b0, d_q, 2'b0};
  assign ss9    = {1'b0, ss_q, 3'b0} + {4'b0, ss_q};
  assign near   = d100 < {3'b000, ss9};
  assign plane  = ady_q < PLANE_LIMIT;
  assign x_olap = {1'b0, adx_q} < ({1'b0, w_in} + {1'b0, rd_w_q});
  assign z_olap = adz_q < ({1'b0, h_in} + {1'b0, rd_h_q});

  // Union of the offered box and the entry.
  logic [31:0]         ux, uy, uz;
  box_t                u_box;
  logic signed [16:0]  u_w;
  logic signed [16:0]  u_h;

  assign ux = union_axis(in_q.lo_x, in_q.hi_x, rd_box_q.lo_x, rd_box_q.hi_x);
  assign uy = union_axis(in_q.lo_y, in_q.hi_y, rd_box_q.lo_y, rd_box_q.hi_y);
  assign uz = union_axis(in_q.lo_z, in_q.hi_z, rd_box_q.lo_z, rd_box_q.hi_z);
  assign u_box = '{hi_z: uz[31:16], hi_y: uy[31:16], hi_x: ux[31:16],
                   lo_z: uz[15:0],  lo_y: uy[15:0],  lo_x: ux[15:0]};
  assign u_w = {ux[31], ux[31:16]} - {ux[15], ux[15:0]};
  assign u_h = {uz[31], uz[31:16]} - {uz[15], uz[15:0]};

  // Memory write and registered read.
  logic [AW-1:0] wr_addr;
  assign wr_addr = (cmd_i.op == OP_MERGE_WR) ? idx_q[AW-1:0] : cnt_q[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_MERGE_WR) begin
      box_mem[wr_addr] <= u_box;
      wid_mem[wr_addr] <= u_w[WIDTH_W-1:0];
      hgt_mem[wr_addr] <= u_h[HEIGHT_W-1:0];
    end else if (cmd_i.op == OP_INS_WR) begin
      box_mem[wr_addr] <= in_q;
      wid_mem[wr_addr] <= w_in;
      hgt_mem[wr_addr] <= h_in;
      key_mem[wr_addr] <= key_q;
    end
    rd_box_q <= box_mem[idx_q[AW-1:0]];
    rd_w_q   <= wid_mem[idx_q[AW-1:0]];
    rd_h_q   <= hgt_mem[idx_q[AW-1:0]];
    rd_key_q <= key_mem[idx_q[AW-1:0]];
  end

  // Output register.
  logic [CNT_W+SLOT_W-1:0] idx_ext, cnt_ext;
  logic [SLOT_W-1:0]       slot_d;
  logic                    out_valid_q;
  logic                    out_free;

  assign idx_ext  = {{SLOT_W{1'b0}}, idx_q};
  assign cnt_ext  = {{SLOT_W{1'b0}}, cnt_q};
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    case (cmd_i.slot_sel)
      SLOT_IDX:   slot_d = idx_ext[SLOT_W-1:0];
      SLOT_COUNT: slot_d = cnt_ext[SLOT_W-1:0];
      default:    slot_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_o <= cmd_i.out_status;
      out_slot_o   <= slot_d;
      out_box_o    <= cmd_i.out_box ? rd_box_q : '0;
      out_last_o   <= cmd_i.out_last;
    end
  end

  assign out_valid_o = out_valid_q;

  // Status to the controller.
  logic [CNT_W:0] idx_next;
  assign idx_next = {1'b0, idx_q} + 1'b1;

  assign status_o.too_small  = (dxy_q < {2'b00, mm_q}) || (h_in < min_size_q);
  assign status_o.sqrt_done  = (sq_bit_q == '0);
  assign status_o.key_match  = (rd_key_q == key_q);
  assign status_o.scan_end   = (idx_q == cnt_q);
  assign status_o.last_entry = (idx_next == {1'b0, cnt_q});
  assign status_o.merge_hit  = near || (plane && x_olap && z_olap);
  assign status_o.table_full = (cnt_q == CNT_W'(TABLE_DEPTH));
  assign status_o.cnt_zero   = (cnt_q == '0);
  assign status_o.out_free   = out_free;
  assign status_o.merge_en   = merge_en_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_ins_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_INS_WR) |-> (cnt_q != CNT_W'(TABLE_DEPTH)))
    else $error("insert into a full table");

  a_out_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> out_free)
    else $error("result loaded over an untaken result");

  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_clr |=> (cnt_q == '0))
    else $error("flush did not empty the table");
`endif

endmodule

`default_nettype wire

>>> rtl/core/wall_box_merge_table.sv
// An offer squares its x and y sides and the size limit, then gives a too-small
// result or forms its keys, takes the 17-step square root and scans the stored keys
// for a duplicate and, with merging on, the entries for a merge candidate; products
// use the shared 18x18 multiplier. One item at a time; flushed entries go in turn.
// Reset: asynchronous, active low; the table is empty at once, no clearing pass.
// Top level of the wall box merge table; depends on wbm_pkg, wbm_ctrl, wbm_dp.
`default_nettype none

module wall_box_merge_table
  import wbm_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Configuration write port.
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_W-1:0]      cfg_data_i,
  // Input stream.
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // tdata: box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
  input  wire logic [BOX_W-1:0]      s_axis_tdata,
  // tuser: command
  input  wire logic                  s_axis_tuser,
  // Result stream.
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // tdata: slot, out_min_x, out_min_y, out_min_z, out_max_x, out_max_y,
  //        out_max_z, four zero bits
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  // tuser: status
  output logic [STATUS_W-1:0]        m_axis_tuser,
  output logic                       m_axis_tlast
);

  dp_cmd_t           cmd;
  dp_status_t        status;
  logic [SLOT_W-1:0] out_slot;
  logic [BOX_W-1:0]  out_box;

  wbm_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_command_i (s_axis_tuser),
    .in_ready_o   (s_axis_tready),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  wbm_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_box_i     (s_axis_tdata),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (m_axis_tuser),
    .out_slot_o   (out_slot),
    .out_box_o    (out_box),
    .out_last_o   (m_axis_tlast)
  );

  // Result transaction payload, slot in the lowest bits.
  assign m_axis_tdata = {4'b0000, out_box, out_slot};

endmodule

`default_nettype wire

>>> tb/tb_wall_box_merge_table.sv
// Self-checking testbench for wall_box_merge_table: directed rows, then random
// offers and flushes under several register settings, checked against a predictor.
// Depends on wbm_pkg and the wall_box_merge_table RTL.
`default_nettype none

module tb_wall_box_merge_table;
  import wbm_pkg::*;

  localparam int DEPTH = 16;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 250;

  // One result as it leaves the block.
  typedef struct {
    res_status_e status;
    logic [3:0]  slot;
    box_t        box;
    logic        last;
  } box_result_t;

  // One row of the directed part; known marks a status read off by hand.
  typedef struct {
    command_e    cmd;
    box_t        box;
    logic        known;
    res_status_e known_status;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [BOX_W-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0] m_axis_tuser;
  logic m_axis_tlast;

  wall_box_merge_table #(.TABLE_DEPTH(DEPTH)) dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  always #1 clk_i = ~clk_i;

  // Predictor state: a copy of the box table and the registers.
  box_t        tbl_box[DEPTH];
  longint      tbl_width[DEPTH];
  longint      tbl_height[DEPTH];
  logic [38:0] tbl_key[DEPTH];
  int          tbl_count;
  int          cfg_min_size;
  bit          cfg_merge_on;

  box_result_t awaited_results[$];
  int  mismatch_count = 0;
  int  idle_cycles = 0;
  bit  quiet_run = 1'b0;
  bit  long_hold_req = 1'b0;

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r = 0;
    longint unsigned b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Doubled center rounded to 10 mm, ties away from zero, 13-bit wrap.
  function automatic logic [12:0] center_key(input longint c);
    longint k;
    k = (c >= 0) ? (c + 10) / 20 : -((-c + 10) / 20);
    return k[12:0];
  endfunction

  function automatic void corners(input box_t b, output longint lo[3], output longint hi[3]);
    lo[0] = b.lo_x; lo[1] = b.lo_y; lo[2] = b.lo_z;
    hi[0] = b.hi_x; hi[1] = b.hi_y; hi[2] = b.hi_z;
  endfunction

  function automatic void push_result(input res_status_e st, input int slot,
                                      input box_t b, input logic last);
    box_result_t r;
    r.status = st; r.slot = slot[3:0]; r.box = b; r.last = last;
    awaited_results = {awaited_results, r};
  endfunction

  // Center-distance test or same-plane plus overlap test against entry e.
  function automatic bit boxes_join(input box_t nb, input longint w, input longint h,
                                    input int e);
    longint a_lo[3], a_hi[3], e_lo[3], e_hi[3];
    longint ad[3];
    longint unsigned d, s;
    longint m1, m2;
    corners(nb, a_lo, a_hi);
    corners(tbl_box[e], e_lo, e_hi);
    d = 0;
    for (int i = 0; i < 3; i++) begin
      ad[i] = (a_lo[i] + a_hi[i]) - (e_lo[i] + e_hi[i]);
      if (ad[i] < 0) ad[i] = -ad[i];
      d += ad[i] * ad[i];
    end
    m1 = (w > h) ? w : h;
    m2 = (tbl_width[e] > tbl_height[e]) ? tbl_width[e] : tbl_height[e];
    s = m1 + m2;
    return (100 * d < 9 * s * s) ||
           (ad[1] < 400 && ad[0] < w + tbl_width[e] && ad[2] < h + tbl_height[e]);
  endfunction

  // Works out the results of one accepted transaction and updates the table.
  function automatic res_status_e predict_table_step(input command_e cmd, input box_t nb);
    longint lo[3], hi[3], e_lo[3], e_hi[3];
    longint dx, dy, h, w, m, l, u, el, eu;
    longint unsigned dxy;
    logic [38:0] key;
    box_t merged;
    if (cmd == CMD_FLUSH) begin
      if (tbl_count == 0) begin
        push_result(RES_FLUSH_EMPTY, 0, '0, 1'b1);
        return RES_FLUSH_EMPTY;
      end
      for (int i = 0; i < tbl_count; i++)
        push_result(RES_FLUSHED, i, tbl_box[i], i + 1 == tbl_count);
      tbl_count = 0;
      return RES_FLUSHED;
    end
    corners(nb, lo, hi);
    dx = hi[0] - lo[0];
    dy = hi[1] - lo[1];
    dxy = dx * dx + dy * dy;
    w = int_sqrt(dxy);
    h = hi[2] - lo[2];
    if (h < 0) h = -h;
    m = cfg_min_size;
    if (dxy < m * m || h < m) begin
      push_result(RES_TOO_SMALL, 0, '0, 1'b1);
      return RES_TOO_SMALL;
    end
    key = {center_key(lo[2] + hi[2]), center_key(lo[1] + hi[1]), center_key(lo[0] + hi[0])};
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_key[i] == key) begin
        push_result(RES_DUPLICATE, i, '0, 1'b1);
        return RES_DUPLICATE;
      end
    end
    if (cfg_merge_on) begin
      for (int i = 0; i < tbl_count; i++) begin
        if (!boxes_join(nb, w, h, i)) continue;
        corners(tbl_box[i], e_lo, e_hi);
        for (int a = 0; a < 3; a++) begin
          l  = (lo[a] < hi[a]) ? lo[a] : hi[a];
          u  = (lo[a] < hi[a]) ? hi[a] : lo[a];
          el = (e_lo[a] < e_hi[a]) ? e_lo[a] : e_hi[a];
          eu = (e_lo[a] < e_hi[a]) ? e_hi[a] : e_lo[a];
          e_lo[a] = (l < el) ? l : el;
          e_hi[a] = (u > eu) ? u : eu;
        end
        merged.lo_x = e_lo[0]; merged.lo_y = e_lo[1]; merged.lo_z = e_lo[2];
        merged.hi_x = e_hi[0]; merged.hi_y = e_hi[1]; merged.hi_z = e_hi[2];
        tbl_box[i] = merged;
        tbl_width[i] = e_hi[0] - e_lo[0];
        tbl_height[i] = e_hi[2] - e_lo[2];
        push_result(RES_MERGED, i, '0, 1'b1);
        return RES_MERGED;
      end
    end
    if (tbl_count >= DEPTH) begin
      push_result(RES_TABLE_FULL, 0, '0, 1'b1);
      return RES_TABLE_FULL;
    end
    tbl_box[tbl_count] = nb;
    tbl_width[tbl_count] = w;
    tbl_height[tbl_count] = h;
    tbl_key[tbl_count] = key;
    push_result(RES_INSERTED, tbl_count, '0, 1'b1);
    tbl_count++;
    return RES_INSERTED;
  endfunction

  function automatic box_t corner_box(input int x0, y0, z0, x1, y1, z1);
    box_t b;
    b.lo_x = x0; b.lo_y = y0; b.lo_z = z0;
    b.hi_x = x1; b.hi_y = y1; b.hi_z = z1;
    return b;
  endfunction

  // A wall box near cluster centers, sometimes with reversed bounds, or fully random.
  function automatic box_t wall_box(input int spread);
    int c[3], half[3], lo[3], hi[3], t;
    box_t b;
    if ($urandom_range(0, 9) == 0) begin
      b = {$urandom, $urandom, $urandom};
      return b;
    end
    for (int a = 0; a < 3; a++) begin
      c[a] = int'($urandom_range(0, spread)) * 1800 - 14000 + int'($urandom_range(0, 300));
      half[a] = $urandom_range(50, 1600);
      lo[a] = c[a] - half[a];
      hi[a] = c[a] + half[a];
      if ($urandom_range(0, 15) == 0) begin
        t = lo[a]; lo[a] = hi[a]; hi[a] = t;
      end
    end
    return corner_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
  endfunction

  task automatic write_register(input cfg_idx_e idx, input int value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value[CFG_W-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_MIN_SIZE) cfg_min_size = value & 16'hFFFF;
    else cfg_merge_on = value[0];
  endtask

  // Offers one transaction and holds it until the block takes it.
  task automatic offer_item(input command_e cmd, input box_t b, output res_status_e first);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    first = predict_table_step(cmd, b);
    if (!quiet_run && $urandom_range(0, 3) == 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(0, 2)) @(negedge clk_i);
    end
  endtask

  task automatic wait_drained;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic random_phase(input int count, input int spread, input int flush_odds);
    res_status_e st;
    for (int n = 0; n < count; n++) begin
      if (n == count / 2 && spread == 6) long_hold_req = 1'b1;
      if ($urandom_range(0, flush_odds) == 0) offer_item(CMD_FLUSH, wall_box(spread), st);
      else offer_item(CMD_OFFER, wall_box(spread), st);
    end
  endtask

  // Result side: readiness with random bursts of stall and one long hold.
  initial begin
    int hold;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        hold = 0;
        while (hold < 90) begin
          @(negedge clk_i);
          hold++;
        end
        m_axis_tready <= 1'b1;
      end else if (!quiet_run && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(0, 2)) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Check every result transaction against the oldest awaited result.
  always @(posedge clk_i) begin
    box_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("result with nothing awaited");
      end else begin
        want = awaited_results.pop_front();
        if (m_axis_tuser !== want.status)
          report_mismatch($sformatf("status %0d, wanted %0d", m_axis_tuser, want.status));
        if (m_axis_tdata[3:0] !== want.slot)
          report_mismatch($sformatf("slot %0d, wanted %0d", m_axis_tdata[3:0], want.slot));
        if (m_axis_tdata[99:4] !== want.box)
          report_mismatch($sformatf("box %h, wanted %h", m_axis_tdata[99:4], want.box));
        if (m_axis_tdata[103:100] !== 4'b0) report_mismatch("pad bits not zero");
        if (m_axis_tlast !== want.last)
          report_mismatch($sformatf("last %b, wanted %b", m_axis_tlast, want.last));
      end
    end
  end

  // Watchdog on cycles with no transaction on either side.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[wall_box_merge_table] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  stim_row_t rows[$];

  initial begin
    res_status_e st;
    tbl_count = 0;
    cfg_min_size = 500;
    cfg_merge_on = 1'b1;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed rows: extremes, both commands, sizes at the limit, reversed bounds.
    rows = '{
      '{CMD_FLUSH, '0, 1'b1, RES_FLUSH_EMPTY},
      '{CMD_OFFER, corner_box(0, 0, 0, 100, 100, 100), 1'b1, RES_TOO_SMALL},
      '{CMD_OFFER, corner_box(-32768, -32768, -32768, 32767, 32767, 32767),
        1'b1, RES_INSERTED},
      '{CMD_OFFER, corner_box(-32768, -32768, -32768, 32767, 32767, 32767),
        1'b1, RES_DUPLICATE},
      '{CMD_OFFER, corner_box(0, 0, 0, 499, 0, 500), 1'b1, RES_TOO_SMALL},
      '{CMD_OFFER, corner_box(0, 0, 0, 500, 0, 499), 1'b1, RES_TOO_SMALL},
      '{CMD_OFFER, corner_box(20000, 20000, 20000, 20500, 20000, 20500), 1'b0, RES_INSERTED},
      '{CMD_FLUSH, '0, 1'b0, RES_FLUSHED},
      '{CMD_OFFER, corner_box(1000, 1000, 1000, 0, 0, 0), 1'b1, RES_INSERTED},
      '{CMD_OFFER, corner_box(100, 100, 100, 1100, 1100, 1100), 1'b1, RES_MERGED},
      '{CMD_OFFER, corner_box(900, 0, 0, 2400, 150, 1000), 1'b0, RES_MERGED},
      '{CMD_OFFER, corner_box(-20000, 5000, -20000, -19000, 5800, -19000), 1'b0, RES_INSERTED},
      '{CMD_OFFER, corner_box(32767, 32767, 32767, -32768, -32768, -32768), 1'b0, RES_INSERTED},
      '{CMD_FLUSH, '0, 1'b0, RES_FLUSHED},
      '{CMD_FLUSH, '0, 1'b1, RES_FLUSH_EMPTY}
    };
    foreach (rows[i]) begin
      offer_item(rows[i].cmd, rows[i].box, st);
      if (rows[i].known && st != rows[i].known_status)
        report_mismatch($sformatf("row %0d predicted %0d", i, st));
    end
    wait_drained();

    // Defaults, with clustered boxes so that merges and duplicates are common.
    random_phase(110, 6, 14);
    wait_drained();

    // Merging off and no size limit: the table fills up.
    write_register(CFG_MERGE_EN, 0);
    write_register(CFG_MIN_SIZE, 0);
    random_phase(90, 15, 30);
    wait_drained();

    // Largest size limit: nearly everything is too small.
    write_register(CFG_MIN_SIZE, 65535);
    random_phase(30, 15, 10);
    offer_item(CMD_OFFER, corner_box(-32768, -32768, -32768, 32767, 32767, 32767), st);
    wait_drained();

    // Random limit with merging back on.
    write_register(CFG_MERGE_EN, 1);
    write_register(CFG_MIN_SIZE, $urandom_range(100, 1500));
    random_phase(110, 10, 18);
    wait_drained();

    // Defaults again, with no idling on either side.
    write_register(CFG_MIN_SIZE, 500);
    quiet_run = 1'b1;
    random_phase(110, 8, 16);
    offer_item(CMD_FLUSH, '0, st);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("[wall_box_merge_table] OK");
    end else begin
      $display("[wall_box_merge_table] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
rtl/core/wbm_pkg.sv
rtl/core/wbm_ctrl.sv
rtl/core/wbm_dp.sv
rtl/core/wall_box_merge_table.sv
tb/tb_wall_box_merge_table.sv
